@@ src/vbfe_pkg.sv @@
// Shared types, constants and helper functions of the voxel boundary face extractor.
`timescale 1ns / 1ps

package vbfe_pkg;

   // Grid geometry
   localparam int MAX_DIM     = 256;
   localparam int DIM_W       = $clog2(MAX_DIM);
   localparam int LAT_W       = $clog2(MAX_DIM + 2);
   localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);

   // Register field widths
   localparam int SIZE_W  = 9;
   localparam int COORD_W = 32;
   localparam int SCALE_W = 31;
   localparam int CSR_AW  = 5;
   localparam int CSR_DW  = 32;

   // Vertex arithmetic widths
   localparam int PROD_W = LAT_W + SCALE_W;
   localparam int SUM_W  = PROD_W + 2;

   // Register indexes
   localparam logic [2:0] REG_SIZE_X     = 3'd0;
   localparam logic [2:0] REG_SIZE_Y     = 3'd1;
   localparam logic [2:0] REG_SIZE_Z     = 3'd2;
   localparam logic [2:0] REG_ORIGIN_X   = 3'd3;
   localparam logic [2:0] REG_ORIGIN_Y   = 3'd4;
   localparam logic [2:0] REG_ORIGIN_Z   = 3'd5;
   localparam logic [2:0] REG_CELL_SCALE = 3'd6;

   // Register reset values
   localparam logic [SIZE_W-1:0]  SIZE_RESET  = 9'd256;
   localparam logic [COORD_W-1:0] ORIGIN_RESET = 32'd0;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 31'd65536;

   // Normal axis codes
   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   // Corner walk of one face: bit k is the u / v offset of vertex k (positive normal)
   localparam int         VERTS_PER_FACE = 6;
   localparam logic [2:0] VERT_LAST      = 3'(VERTS_PER_FACE - 1);
   localparam logic [VERTS_PER_FACE-1:0] DU_POS = 6'b001110;
   localparam logic [VERTS_PER_FACE-1:0] DV_POS = 6'b011100;

   // One voxel as it enters the face sequencer
   typedef struct packed {
      logic [DIM_W-1:0] x;
      logic [DIM_W-1:0] y;
      logic [DIM_W-1:0] z;
      logic             cur;
      logic             prev;
   } item_type;

   // One vertex on lattice coordinates
   typedef struct packed {
      logic [LAT_W-1:0] lat_x;
      logic [LAT_W-1:0] lat_y;
      logic [LAT_W-1:0] lat_z;
      logic [1:0]       axis;
      logic             neg;
      logic             last;
   } vertex_type;

   // Size register to effective extent: zero acts as one, large values as MAX_DIM
   function automatic logic [LAT_W-1:0] clamp_size(input logic [SIZE_W-1:0] s);
      int v;
      v = int'(s);
      if (v == 0) v = 1;
      if (v > MAX_DIM) v = MAX_DIM;
      return LAT_W'(v);
   endfunction

endpackage

@@ src/vbfe_ram.sv @@
// Generic single-clock RAM, one write and one registered read port, read-first.
`timescale 1ns / 1ps

module vbfe_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Read returns the old contents when the same entry is written in that cycle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ src/vbfe_scan.sv @@
// Raster position counters and the plane store (two copies for two reads per voxel).
`timescale 1ns / 1ps

module vbfe_scan (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [vbfe_pkg::SIZE_W-1:0]   size_x,
   input  logic [vbfe_pkg::SIZE_W-1:0]   size_y,
   input  logic [vbfe_pkg::SIZE_W-1:0]   size_z,
   input  logic                          req_valid,
   input  logic                          occupied,
   output logic                          req_ready,
   input  logic                          seq_ready,
   output logic                          accept,
   output vbfe_pkg::item_type            item,
   output logic                          below_bit,
   output logic                          back_bit
);
   import vbfe_pkg::*;

   logic [DIM_W-1:0]  count_x_ff, count_x_in;
   logic [DIM_W-1:0]  count_y_ff, count_y_in;
   logic [DIM_W-1:0]  count_z_ff, count_z_in;
   logic              prev_ff;
   logic [LAT_W-1:0]  ext_x, ext_y, ext_z;
   logic [LAT_W-1:0]  x_p1, y_p1, z_p1;
   logic [ADDR_W-1:0] idx, below_idx;

   assign req_ready = seq_ready;
   assign accept    = req_valid && seq_ready;

   // Voxel handed to the sequencer at the accept edge
   always_comb begin
      item.x    = count_x_ff;
      item.y    = count_y_ff;
      item.z    = count_z_ff;
      item.cur  = occupied;
      item.prev = prev_ff;
   end

   // Column address of this voxel and of its neighbor one row back
   assign idx = ADDR_W'(ADDR_W'(count_y_ff) * ADDR_W'(MAX_DIM) + ADDR_W'(count_x_ff));
   assign below_idx = (count_y_ff == '0) ? '0 :
      ADDR_W'(ADDR_W'(count_y_ff - DIM_W'(1)) * ADDR_W'(MAX_DIM) + ADDR_W'(count_x_ff));

   // Copy used for the neighbor in the row below (y - 1)
   vbfe_ram #(.WIDTH(1), .DEPTH(STORE_DEPTH)) u_plane_below (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (idx),
      .wr_data (occupied),
      .rd_en   (accept),
      .rd_addr (below_idx),
      .rd_data (below_bit)
   );

   // Copy used for the neighbor in the plane behind (z - 1), read before overwrite
   vbfe_ram #(.WIDTH(1), .DEPTH(STORE_DEPTH)) u_plane_back (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (idx),
      .wr_data (occupied),
      .rd_en   (accept),
      .rd_addr (idx),
      .rd_data (back_bit)
   );

   // Raster counters, x fastest
   assign ext_x = clamp_size(size_x);
   assign ext_y = clamp_size(size_y);
   assign ext_z = clamp_size(size_z);
   assign x_p1  = LAT_W'(count_x_ff) + LAT_W'(1);
   assign y_p1  = LAT_W'(count_y_ff) + LAT_W'(1);
   assign z_p1  = LAT_W'(count_z_ff) + LAT_W'(1);

   always_comb begin
      count_x_in = count_x_ff;
      count_y_in = count_y_ff;
      count_z_in = count_z_ff;
      if (accept) begin
         if (x_p1 >= ext_x) begin
            count_x_in = '0;
            if (y_p1 >= ext_y) begin
               count_y_in = '0;
               count_z_in = (z_p1 >= ext_z) ? '0 : DIM_W'(z_p1);
            end else begin
               count_y_in = DIM_W'(y_p1);
            end
         end else begin
            count_x_in = DIM_W'(x_p1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_x_ff <= '0;
         count_y_ff <= '0;
         count_z_ff <= '0;
         prev_ff    <= 1'b0;
      end else begin
         count_x_ff <= count_x_in;
         count_y_ff <= count_y_in;
         count_z_ff <= count_z_in;
         if (accept) begin
            prev_ff <= occupied;
         end
      end
   end

endmodule

@@ src/vbfe_face_seq.sv @@
// Face sequencer: finds the boundary faces of one voxel and walks their six vertices.
`timescale 1ns / 1ps

module vbfe_face_seq (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  vbfe_pkg::item_type  item_in,
   input  logic                below_bit,
   input  logic                back_bit,
   output logic                seq_ready,
   output logic                vtx_valid,
   output vbfe_pkg::vertex_type vtx,
   input  logic                vp_ready
);
   import vbfe_pkg::*;

   logic             busy_ff;
   item_type         item_ff;
   logic [2:0]       vert_ff, vert_in;
   logic [2:0]       done_ff, done_in;
   logic [2:0]       mask, pending, rest;
   logic [1:0]       axis;
   logic             emit, face_end, finish;
   logic             du, dv;
   logic [LAT_W-1:0] p, u, v, cu, cv;

   // Which neighbor pairs differ; RAM data is stable while the voxel is held
   assign mask[0] = (item_ff.x != '0) && (item_ff.prev != item_ff.cur);
   assign mask[1] = (item_ff.y != '0) && (below_bit != item_ff.cur);
   assign mask[2] = (item_ff.z != '0) && (back_bit != item_ff.cur);
   assign pending = mask & ~done_ff;

   // Lowest pending axis goes first
   always_comb begin
      if (pending[0]) begin
         axis = AXIS_X;
         rest = {pending[2:1], 1'b0};
      end else if (pending[1]) begin
         axis = AXIS_Y;
         rest = {pending[2], 2'b00};
      end else begin
         axis = AXIS_Z;
         rest = 3'b000;
      end
   end

   assign emit      = busy_ff && (pending != '0) && vp_ready;
   assign face_end  = emit && (vert_ff == VERT_LAST);
   assign finish    = busy_ff && ((pending == '0) || (face_end && (rest == '0)));
   assign seq_ready = !busy_ff || finish;

   // Corner offsets; a negative normal walks the square the other way round
   assign du = item_ff.cur ? DV_POS[vert_ff] : DU_POS[vert_ff];
   assign dv = item_ff.cur ? DU_POS[vert_ff] : DV_POS[vert_ff];

   always_comb begin
      case (axis)
         AXIS_X: begin
            p = LAT_W'(item_ff.x);
            u = LAT_W'(item_ff.y);
            v = LAT_W'(item_ff.z);
         end
         AXIS_Y: begin
            p = LAT_W'(item_ff.y);
            u = LAT_W'(item_ff.z);
            v = LAT_W'(item_ff.x);
         end
         default: begin
            p = LAT_W'(item_ff.z);
            u = LAT_W'(item_ff.x);
            v = LAT_W'(item_ff.y);
         end
      endcase
   end

   assign cu = u + LAT_W'(du);
   assign cv = v + LAT_W'(dv);

   // Map plane / u / v back onto x, y, z
   always_comb begin
      case (axis)
         AXIS_X: begin
            vtx.lat_x = p;
            vtx.lat_y = cu;
            vtx.lat_z = cv;
         end
         AXIS_Y: begin
            vtx.lat_y = p;
            vtx.lat_z = cu;
            vtx.lat_x = cv;
         end
         default: begin
            vtx.lat_z = p;
            vtx.lat_x = cu;
            vtx.lat_y = cv;
         end
      endcase
      vtx.axis = axis;
      vtx.neg  = item_ff.cur;
      vtx.last = (vert_ff == VERT_LAST) && (rest == '0);
   end

   assign vtx_valid = busy_ff && (pending != '0);

   // Vertex and face progress
   always_comb begin
      vert_in = vert_ff;
      done_in = done_ff;
      if (accept || finish) begin
         vert_in = '0;
         done_in = '0;
      end else if (face_end) begin
         vert_in       = '0;
         done_in[axis] = 1'b1;
      end else if (emit) begin
         vert_in = vert_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         vert_ff <= '0;
         done_ff <= '0;
      end else begin
         vert_ff <= vert_in;
         done_ff <= done_in;
         if (accept) begin
            busy_ff <= 1'b1;
         end else if (finish) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff <= item_in;
      end
   end

endmodule

@@ src/vbfe_vertex_pipe.sv @@
// Vertex pipeline: lattice times scale, then origin add with saturation into the output register.
`timescale 1ns / 1ps

module vbfe_vertex_pipe (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          vtx_valid,
   input  vbfe_pkg::vertex_type          vtx,
   output logic                          vp_ready,
   input  logic [vbfe_pkg::COORD_W-1:0]  origin_x,
   input  logic [vbfe_pkg::COORD_W-1:0]  origin_y,
   input  logic [vbfe_pkg::COORD_W-1:0]  origin_z,
   input  logic [vbfe_pkg::SCALE_W-1:0]  cell_scale,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [vbfe_pkg::COORD_W-1:0]  pos_x,
   output logic [vbfe_pkg::COORD_W-1:0]  pos_y,
   output logic [vbfe_pkg::COORD_W-1:0]  pos_z,
   output logic [1:0]                    normal_axis,
   output logic                          normal_negative,
   output logic                          last_of_item
);
   import vbfe_pkg::*;

   localparam logic signed [SUM_W-1:0] SAT_MAX = {{(SUM_W-COORD_W+1){1'b0}}, {(COORD_W-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SAT_MIN = {{(SUM_W-COORD_W+1){1'b1}}, {(COORD_W-1){1'b0}}};

   // Origin plus product, clamped to the signed coordinate range
   function automatic logic [COORD_W-1:0] sat_add(input logic [COORD_W-1:0] org,
                                                   input logic [PROD_W-1:0]  prod);
      logic signed [SUM_W-1:0] sum;
      sum = $signed({{(SUM_W-COORD_W){org[COORD_W-1]}}, org}) + $signed({2'b00, prod});
      if (sum > SAT_MAX) begin
         return SAT_MAX[COORD_W-1:0];
      end else if (sum < SAT_MIN) begin
         return SAT_MIN[COORD_W-1:0];
      end
      return sum[COORD_W-1:0];
   endfunction

   logic              prod_valid_ff;
   logic [PROD_W-1:0] prod_x_ff, prod_y_ff, prod_z_ff;
   vertex_type        prod_vtx_ff;
   logic              prod_ready, o_ready;
   logic              o_valid_ff;
   logic [COORD_W-1:0] pos_x_ff, pos_y_ff, pos_z_ff;
   vertex_type        o_vtx_ff;

   // Stages move forward whenever the next one is empty or draining
   assign o_ready    = !o_valid_ff || out_ready;
   assign prod_ready = !prod_valid_ff || o_ready;
   assign vp_ready   = prod_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         o_valid_ff    <= 1'b0;
      end else begin
         if (prod_ready) begin
            prod_valid_ff <= vtx_valid;
         end
         if (o_ready) begin
            o_valid_ff <= prod_valid_ff;
         end
      end
   end

   // Multiply stage
   always_ff @(posedge clock) begin
      if (prod_ready && vtx_valid) begin
         prod_x_ff   <= PROD_W'(vtx.lat_x) * PROD_W'(cell_scale);
         prod_y_ff   <= PROD_W'(vtx.lat_y) * PROD_W'(cell_scale);
         prod_z_ff   <= PROD_W'(vtx.lat_z) * PROD_W'(cell_scale);
         prod_vtx_ff <= vtx;
      end
   end

   // Add, saturate, hold for the result channel
   always_ff @(posedge clock) begin
      if (o_ready && prod_valid_ff) begin
         pos_x_ff <= sat_add(origin_x, prod_x_ff);
         pos_y_ff <= sat_add(origin_y, prod_y_ff);
         pos_z_ff <= sat_add(origin_z, prod_z_ff);
         o_vtx_ff <= prod_vtx_ff;
      end
   end

   assign out_valid       = o_valid_ff;
   assign pos_x           = pos_x_ff;
   assign pos_y           = pos_y_ff;
   assign pos_z           = pos_z_ff;
   assign normal_axis     = o_vtx_ff.axis;
   assign normal_negative = o_vtx_ff.neg;
   assign last_of_item    = o_vtx_ff.last;

endmodule

@@ src/voxel_boundary_face_extractor.sv @@
// Top level: register port, raster scan with plane store, face sequencer, vertex pipeline.
`timescale 1ns / 1ps

// Occupancy bits stream in on req_ in raster order (x fastest, then y, then z); a voxel
// yields one square face for each neighbor at x-1, y-1 or z-1 that it differs from, sent on
// rsp_ as six vertices in x, y, z normal order, with tlast on the final vertex of the voxel.
// Voxels that make no face stream at one per cycle; a voxel with faces holds the face
// sequencer until all of its vertices (6, 12 or 18) are handed on, one vertex per cycle
// while the vertex pipeline is ready. Input and output are decoupled by the multiply stage
// and the output register; after its voxel is accepted a vertex passes the registered
// plane store read, the multiply and the origin add. The plane store is two 64K x 1 RAM
// copies written at every accepted voxel; it is not cleared after reset and needs no
// clearing pass, since a grid writes each column before it reads it. Program the registers
// only while no voxel is in flight.
module voxel_boundary_face_extractor (
   input  logic                         clock,
   input  logic                         reset,
   // input voxels
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,   // [0] occupied, [7:1] zero
   // output vertices
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [95:0]                  rsp_tdata,   // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z
   output logic [2:0]                   rsp_tuser,   // [1:0] normal_axis, [2] normal_negative
   output logic                         rsp_tlast,   // last_of_item
   // register port
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [vbfe_pkg::CSR_AW-1:0]  csr_paddr,
   input  logic [vbfe_pkg::CSR_DW-1:0]  csr_pwdata,
   output logic [vbfe_pkg::CSR_DW-1:0]  csr_prdata,
   output logic                         csr_pready
);
   import vbfe_pkg::*;

   logic [SIZE_W-1:0]  size_x_ff, size_y_ff, size_z_ff;
   logic [COORD_W-1:0] origin_x_ff, origin_y_ff, origin_z_ff;
   logic [SCALE_W-1:0] cell_scale_ff;
   logic               csr_write;
   logic [2:0]         csr_index;

   logic               seq_ready, accept, below_bit, back_bit;
   item_type           item;
   logic               vtx_valid, vp_ready;
   vertex_type         vtx;
   logic [COORD_W-1:0] pos_x, pos_y, pos_z;
   logic [1:0]         normal_axis;
   logic               normal_negative;

   // Register file
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[CSR_AW-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff     <= SIZE_RESET;
         size_y_ff     <= SIZE_RESET;
         size_z_ff     <= SIZE_RESET;
         origin_x_ff   <= ORIGIN_RESET;
         origin_y_ff   <= ORIGIN_RESET;
         origin_z_ff   <= ORIGIN_RESET;
         cell_scale_ff <= SCALE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_SIZE_X:     size_x_ff     <= csr_pwdata[SIZE_W-1:0];
            REG_SIZE_Y:     size_y_ff     <= csr_pwdata[SIZE_W-1:0];
            REG_SIZE_Z:     size_z_ff     <= csr_pwdata[SIZE_W-1:0];
            REG_ORIGIN_X:   origin_x_ff   <= csr_pwdata;
            REG_ORIGIN_Y:   origin_y_ff   <= csr_pwdata;
            REG_ORIGIN_Z:   origin_z_ff   <= csr_pwdata;
            REG_CELL_SCALE: cell_scale_ff <= csr_pwdata[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (csr_index)
         REG_SIZE_X:     csr_prdata = CSR_DW'(size_x_ff);
         REG_SIZE_Y:     csr_prdata = CSR_DW'(size_y_ff);
         REG_SIZE_Z:     csr_prdata = CSR_DW'(size_z_ff);
         REG_ORIGIN_X:   csr_prdata = origin_x_ff;
         REG_ORIGIN_Y:   csr_prdata = origin_y_ff;
         REG_ORIGIN_Z:   csr_prdata = origin_z_ff;
         REG_CELL_SCALE: csr_prdata = CSR_DW'(cell_scale_ff);
         default:        csr_prdata = '0;
      endcase
   end

   vbfe_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .size_x    (size_x_ff),
      .size_y    (size_y_ff),
      .size_z    (size_z_ff),
      .req_valid (req_tvalid),
      .occupied  (req_tdata[0]),
      .req_ready (req_tready),
      .seq_ready (seq_ready),
      .accept    (accept),
      .item      (item),
      .below_bit (below_bit),
      .back_bit  (back_bit)
   );

   vbfe_face_seq u_face_seq (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .item_in   (item),
      .below_bit (below_bit),
      .back_bit  (back_bit),
      .seq_ready (seq_ready),
      .vtx_valid (vtx_valid),
      .vtx       (vtx),
      .vp_ready  (vp_ready)
   );

   vbfe_vertex_pipe u_vertex_pipe (
      .clock           (clock),
      .reset           (reset),
      .vtx_valid       (vtx_valid),
      .vtx             (vtx),
      .vp_ready        (vp_ready),
      .origin_x        (origin_x_ff),
      .origin_y        (origin_y_ff),
      .origin_z        (origin_z_ff),
      .cell_scale      (cell_scale_ff),
      .out_valid       (rsp_tvalid),
      .out_ready       (rsp_tready),
      .pos_x           (pos_x),
      .pos_y           (pos_y),
      .pos_z           (pos_z),
      .normal_axis     (normal_axis),
      .normal_negative (normal_negative),
      .last_of_item    (rsp_tlast)
   );

   assign rsp_tdata = {pos_z, pos_y, pos_x};
   assign rsp_tuser = {normal_negative, normal_axis};

endmodule

@@ bench/voxel_boundary_face_extractor_test.sv @@
// Self-checking testbench for the voxel boundary face extractor.
`timescale 1ns / 1ps

// Streams occupancy bits into the block, predicts every vertex from a local copy of the
// scan state, and compares each vertex transaction in order. Directed tests cover reset
// extents, size clamping, mid-grid size cuts and saturation. Stall tests hold the output
// off and pause the input. Random grids then vary extents, origin, scale and density.
module voxel_boundary_face_extractor_test;
   import vbfe_pkg::*;

   localparam logic [2:0] REG_UNUSED    = 3'd7;     // beyond the register list
   localparam int         SETTLE_CYCLES = 12;       // pipeline drain for voxels with no faces
   localparam int         HOLD_CYCLES   = 300;      // long output hold-off
   localparam int         RANDOM_ITEMS  = 100;
   localparam int         ROW_LENGTH    = 64;
   localparam longint     POS_MAX       = 64'sd2147483647;
   localparam longint     POS_MIN       = -64'sd2147483648;
   // corner walk of a face with positive normal; a negative one swaps u and v
   localparam bit [0:5]   WALK_U        = 6'b011100;
   localparam bit [0:5]   WALK_V        = 6'b001110;

   typedef struct {
      logic [31:0] pos_x;
      logic [31:0] pos_y;
      logic [31:0] pos_z;
      logic [1:0]  axis;
      logic        neg;
      logic        last;
   } vertex_want_type;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_tvalid  = 1'b0;
   logic         req_tready;
   logic [7:0]   req_tdata   = 8'd0;   // [0] occupied, [7:1] zero
   logic         rsp_tvalid;
   logic         rsp_tready  = 1'b0;
   logic [95:0]  rsp_tdata;            // [31:0] pos_x, [63:32] pos_y, [95:64] pos_z
   logic [2:0]   rsp_tuser;            // [1:0] normal_axis, [2] normal_negative
   logic         rsp_tlast;
   logic         csr_psel    = 1'b0;
   logic         csr_penable = 1'b0;
   logic         csr_pwrite  = 1'b0;
   logic [CSR_AW-1:0] csr_paddr  = '0;
   logic [CSR_DW-1:0] csr_pwdata = '0;
   logic [CSR_DW-1:0] csr_prdata;
   logic         csr_pready;

   // scan state and register copy of the face predictor
   bit           occ_plane [STORE_DEPTH];
   bit           prev_occ;
   int           scan_x, scan_y, scan_z;
   logic [8:0]   reg_size [3];
   longint       reg_origin [3];
   longint       reg_scale;
   vertex_want_type expected_vertices [$];

   // run bookkeeping
   int           mismatch_count   = 0;
   int           voxels_sent      = 0;
   int           vertices_checked = 0;
   int           random_grids     = 0;
   bit           steady_flow      = 1'b0;
   int           hold_request     = 0;
   int           ready_gap        = 0;
   int           ready_draw;

   voxel_boundary_face_extractor dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // Idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady_flow || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   function automatic int eff_extent(input logic [8:0] s);
      if (s == 9'd0) return 1;
      if (int'(s) > MAX_DIM) return MAX_DIM;
      return int'(s);
   endfunction

   // origin + lattice * scale, clipped to signed 32 bits
   function automatic logic [31:0] lattice_to_pos(input longint org, input int lat);
      longint r;
      r = org + longint'(lat) * reg_scale;
      if (r > POS_MAX) r = POS_MAX;
      if (r < POS_MIN) r = POS_MIN;
      return r[31:0];
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      if (mismatch_count <= 40) $display("ERROR @%0t: %s", $time, msg);
   endtask

   // Six vertices of one face on plane p of the given axis
   task automatic push_face(input logic [1:0] axis, input bit neg, input int p,
                            input int u, input int v);
      int              k, cu, cv, lx, ly, lz;
      vertex_want_type vtx;
      for (k = 0; k < 6; k++) begin
         cu = u + (neg ? WALK_V[k] : WALK_U[k]);
         cv = v + (neg ? WALK_U[k] : WALK_V[k]);
         case (axis)
            AXIS_X: begin
               lx = p;  ly = cu; lz = cv;
            end
            AXIS_Y: begin
               lx = cv; ly = p;  lz = cu;
            end
            default: begin
               lx = cu; ly = cv; lz = p;
            end
         endcase
         vtx.pos_x = lattice_to_pos(reg_origin[0], lx);
         vtx.pos_y = lattice_to_pos(reg_origin[1], ly);
         vtx.pos_z = lattice_to_pos(reg_origin[2], lz);
         vtx.axis  = axis;
         vtx.neg   = neg;
         vtx.last  = 1'b0;
         expected_vertices.insert(expected_vertices.size(), vtx);
      end
   endtask

   // Faces caused by one accepted voxel, then scan advance
   task automatic predict_voxel(input bit occ);
      int x, y, z, idx, faces;
      x = scan_x;
      y = scan_y;
      z = scan_z;
      idx = y * MAX_DIM + x;
      faces = 0;
      if (x > 0 && prev_occ != occ) begin
         push_face(AXIS_X, occ, x, y, z);
         faces++;
      end
      if (y > 0 && occ_plane[idx - MAX_DIM] != occ) begin
         push_face(AXIS_Y, occ, y, z, x);
         faces++;
      end
      if (z > 0 && occ_plane[idx] != occ) begin
         push_face(AXIS_Z, occ, z, x, y);
         faces++;
      end
      if (faces > 0) expected_vertices[expected_vertices.size() - 1].last = 1'b1;
      occ_plane[idx] = occ;
      prev_occ = occ;
      if (x + 1 >= eff_extent(reg_size[0])) begin
         scan_x = 0;
         if (y + 1 >= eff_extent(reg_size[1])) begin
            scan_y = 0;
            scan_z = (z + 1 >= eff_extent(reg_size[2])) ? 0 : z + 1;
         end else begin
            scan_y = y + 1;
         end
      end else begin
         scan_x = x + 1;
      end
   endtask

   // One register write: setup cycle, access cycle
   task automatic write_reg(input logic [2:0] index, input logic [31:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      case (index)
         REG_SIZE_X:     reg_size[0]   = value[8:0];
         REG_SIZE_Y:     reg_size[1]   = value[8:0];
         REG_SIZE_Z:     reg_size[2]   = value[8:0];
         REG_ORIGIN_X:   reg_origin[0] = longint'($signed(value));
         REG_ORIGIN_Y:   reg_origin[1] = longint'($signed(value));
         REG_ORIGIN_Z:   reg_origin[2] = longint'($signed(value));
         REG_CELL_SCALE: reg_scale     = longint'(value[30:0]);
         default: ;
      endcase
   endtask

   // Offer one voxel, wait for its transaction, predict its vertices
   task automatic send_voxel(input bit occ);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, occ};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_voxel(occ);
      voxels_sent++;
   endtask

   // Stop sending and wait until every vertex has come back
   task automatic await_results();
      req_tvalid <= 1'b0;
      while (expected_vertices.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic finish_grid(input int density);
      do begin
         send_voxel($urandom_range(0, 99) < density);
      end while (scan_x != 0 || scan_y != 0 || scan_z != 0);
   endtask

   function automatic logic [31:0] pick_origin();
      logic [31:0] w;
      w = $urandom();
      case ($urandom_range(0, 3))
         0: return w;
         1: return w[31] ? (w | 32'hFFF0_0000) : (w & 32'h000F_FFFF);
         2: return 32'h7FFF_0000 | w[15:0];
         default: return 32'h8000_0000 | w[15:0];
      endcase
   endfunction

   function automatic logic [31:0] pick_scale();
      case ($urandom_range(0, 4))
         0: return 32'd0;
         1: return 32'h0001_0000;
         2: return $urandom();
         3: return 32'h7FFF_FFFF;
         default: return $urandom_range(1, 32'h0010_0000);
      endcase
   endfunction

   // Reset extents (256 each), then cut sizes mid-grid below the counters
   task automatic test_reset_state();
      bit [0:5] first_row;
      int       i;
      first_row = 6'b110100;
      for (i = 0; i < 6; i++) send_voxel(first_row[i]);
      await_results();
      write_reg(REG_SIZE_X, 32'd2);
      write_reg(REG_SIZE_Y, 32'd2);
      write_reg(REG_SIZE_Z, 32'd2);
      finish_grid(50);
   endtask

   // Size zero acts as one, sizes above 256 as 256, upper bits ignored
   task automatic test_size_clamping();
      int i;
      await_results();
      write_reg(REG_SIZE_X, 32'hFFFF_FE00);
      write_reg(REG_SIZE_Y, 32'h0000_01FF);
      write_reg(REG_SIZE_Z, 32'd256);
      for (i = 0; i < 4; i++) send_voxel(i[0]);
      await_results();
      write_reg(REG_SIZE_Y, 32'h8000_0202);
      write_reg(REG_SIZE_Z, 32'd0);
      write_reg(REG_UNUSED, 32'hFFFF_FFFF);
      send_voxel(1'b1);
      await_results();
      // one plane per grid: no z face across the wrap
      write_reg(REG_SIZE_X, 32'd2);
      write_reg(REG_SIZE_Y, 32'd2);
      for (i = 0; i < 8; i++) send_voxel(i < 4);
   endtask

   // Checkerboard 2x2x2: all axes, both normals, 18 vertices on one voxel, clipping
   task automatic test_saturation();
      bit [0:7] checker_bits;
      int       i;
      checker_bits = 8'b0110_1001;
      await_results();
      write_reg(REG_SIZE_Z, 32'd2);
      write_reg(REG_ORIGIN_X, 32'h7FFF_0000);
      write_reg(REG_ORIGIN_Y, 32'h8000_0000);
      write_reg(REG_ORIGIN_Z, 32'd0);
      write_reg(REG_CELL_SCALE, 32'hFFFF_FFFF);
      for (i = 0; i < 8; i++) send_voxel(checker_bits[i]);
   endtask

   // Long output hold-off while input keeps coming, then a full input pause
   task automatic test_input_stall();
      int i;
      await_results();
      write_reg(REG_SIZE_X, 32'd3);
      write_reg(REG_SIZE_Y, 32'd3);
      write_reg(REG_SIZE_Z, 32'd3);
      write_reg(REG_ORIGIN_X, pick_origin());
      write_reg(REG_ORIGIN_Y, pick_origin());
      write_reg(REG_ORIGIN_Z, pick_origin());
      write_reg(REG_CELL_SCALE, 32'h0001_0000);
      steady_flow  = 1'b1;
      hold_request = HOLD_CYCLES;
      for (i = 0; i < 13; i++) send_voxel((scan_x + scan_y + scan_z) % 2 == 1);
      steady_flow = 1'b0;
      await_results();
      do begin
         send_voxel((scan_x + scan_y + scan_z) % 2 == 0);
      end while (scan_x != 0 || scan_y != 0 || scan_z != 0);
   endtask

   // One long row along x: lattice coordinates well past the small grids
   task automatic test_long_row();
      await_results();
      write_reg(REG_SIZE_X, 32'(ROW_LENGTH));
      write_reg(REG_SIZE_Y, 32'd1);
      write_reg(REG_SIZE_Z, 32'd1);
      write_reg(REG_ORIGIN_X, pick_origin());
      write_reg(REG_CELL_SCALE, pick_scale());
      finish_grid($urandom_range(20, 80));
   endtask

   // Random extents, origin, scale and density; some grids get mid-grid rewrites
   task automatic test_random_grids();
      int          sent, density, grids, g;
      logic [31:0] w;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         await_results();
         steady_flow = ($urandom_range(0, 3) == 0);
         w = $urandom();
         write_reg(REG_SIZE_X, {w[31:9], 9'($urandom_range(0, 4))});
         w = $urandom();
         write_reg(REG_SIZE_Y, {w[31:9], 9'($urandom_range(0, 4))});
         w = $urandom();
         write_reg(REG_SIZE_Z, {w[31:9], 9'($urandom_range(0, 4))});
         write_reg(REG_ORIGIN_X, pick_origin());
         write_reg(REG_ORIGIN_Y, pick_origin());
         write_reg(REG_ORIGIN_Z, pick_origin());
         write_reg(REG_CELL_SCALE, pick_scale());
         density = $urandom_range(10, 90);
         grids = $urandom_range(1, 2);
         for (g = 0; g < grids; g++) begin
            do begin
               send_voxel($urandom_range(0, 99) < density);
               sent++;
               // mid-grid: only shrink x so every plane entry read was written
               if ((scan_x | scan_y | scan_z) != 0 && $urandom_range(0, 24) == 0) begin
                  await_results();
                  write_reg(REG_SIZE_X, 32'($urandom_range(1, eff_extent(reg_size[0]))));
                  write_reg(REG_ORIGIN_Y, pick_origin());
                  write_reg(REG_CELL_SCALE, pick_scale());
               end
            end while (scan_x != 0 || scan_y != 0 || scan_z != 0);
            random_grids++;
         end
      end
      steady_flow = 1'b0;
   endtask

   // Output ready: random stalls, plus the long hold-off on request
   always @(posedge clock) begin
      if (hold_request > 0) begin
         ready_gap    = hold_request;
         hold_request = 0;
      end
      if (ready_gap > 0) begin
         ready_gap = ready_gap - 1;
         rsp_tready <= 1'b0;
      end else begin
         ready_draw = pick_gap();
         if (ready_draw == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            ready_gap = ready_draw - 1;
            rsp_tready <= 1'b0;
         end
      end
   end

   // Compare each vertex transaction with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_vertices.size() == 0) begin
            report_mismatch($sformatf("vertex %0d arrived with nothing expected",
                                      vertices_checked));
         end else begin
            automatic vertex_want_type want = expected_vertices.pop_front();
            if (rsp_tdata[31:0] !== want.pos_x)
               report_mismatch($sformatf("vertex %0d pos_x %h, expected %h",
                                         vertices_checked, rsp_tdata[31:0], want.pos_x));
            if (rsp_tdata[63:32] !== want.pos_y)
               report_mismatch($sformatf("vertex %0d pos_y %h, expected %h",
                                         vertices_checked, rsp_tdata[63:32], want.pos_y));
            if (rsp_tdata[95:64] !== want.pos_z)
               report_mismatch($sformatf("vertex %0d pos_z %h, expected %h",
                                         vertices_checked, rsp_tdata[95:64], want.pos_z));
            if (rsp_tuser[1:0] !== want.axis)
               report_mismatch($sformatf("vertex %0d normal_axis %0d, expected %0d",
                                         vertices_checked, rsp_tuser[1:0], want.axis));
            if (rsp_tuser[2] !== want.neg)
               report_mismatch($sformatf("vertex %0d normal_negative %b, expected %b",
                                         vertices_checked, rsp_tuser[2], want.neg));
            if (rsp_tlast !== want.last)
               report_mismatch($sformatf("vertex %0d last_of_item %b, expected %b",
                                         vertices_checked, rsp_tlast, want.last));
         end
         vertices_checked++;
      end
   end

   // Test sequence
   initial begin
      prev_occ   = 1'b0;
      scan_x     = 0;
      scan_y     = 0;
      scan_z     = 0;
      reg_size   = '{SIZE_RESET, SIZE_RESET, SIZE_RESET};
      reg_origin = '{0, 0, 0};
      reg_scale  = longint'(SCALE_RESET);
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_state();
      test_size_clamping();
      test_saturation();
      test_input_stall();
      test_long_row();
      test_random_grids();
      await_results();
      $display("run: %0d voxels sent, %0d vertices checked, %0d random grids",
               voxels_sent, vertices_checked, random_grids);
      $display("run: reset extents, size clamping, mid-grid cuts, clipping, long row, stalls");
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   // Hang guard
   initial begin
      #25_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
